### sv/jcs_pkg.sv
// Shared types and constants for the JSON container splitter.
package jcs_pkg;

  // Characters that steer the parser.
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  // Parser phase, one-hot.
  typedef enum logic [7:0] {
    PH_IDLE        = 8'b0000_0001,
    PH_OPENED      = 8'b0000_0010,
    PH_NEED_ITEM   = 8'b0000_0100,
    PH_KEY         = 8'b0000_1000,
    PH_NEED_VALUE  = 8'b0001_0000,
    PH_IN_VALUE    = 8'b0010_0000,
    PH_AFTER_VALUE = 8'b0100_0000,
    PH_DRAIN       = 8'b1000_0000
  } phase_e;

  // Kind of a reported event.
  typedef enum logic [2:0] {
    EV_ELEMENT = 3'd0,
    EV_KEY     = 3'd1,
    EV_VALUE   = 3'd2,
    EV_CLOSED  = 3'd3,
    EV_ERROR   = 3'd4
  } event_kind_e;

  // Decoded class of one text byte.
  typedef struct packed {
    logic white;
    logic lbrack;
    logic lbrace;
    logic rbrack;
    logic rbrace;
    logic quote;
    logic bslash;
    logic comma;
    logic colon;
  } char_class_t;

  // Parser status seen by the top level.
  typedef struct packed {
    logic idle;
    logic clean;
  } parser_stat_t;

endpackage

### sv/jcs_classify.sv
// Character class decoder for one text byte.
module jcs_classify
  import jcs_pkg::*;
(
  input  logic [7:0]  byte_i,
  output char_class_t class_o
);

  // Compare the byte against each structural character.
  always_comb begin
    class_o.white  = (byte_i <= CH_SPACE);
    class_o.lbrack = (byte_i == CH_LBRACK);
    class_o.lbrace = (byte_i == CH_LBRACE);
    class_o.rbrack = (byte_i == CH_RBRACK);
    class_o.rbrace = (byte_i == CH_RBRACE);
    class_o.quote  = (byte_i == CH_QUOTE);
    class_o.bslash = (byte_i == CH_BSLASH);
    class_o.comma  = (byte_i == CH_COMMA);
    class_o.colon  = (byte_i == CH_COLON);
  end

endmodule

### sv/jcs_parser.sv
// Parser state and per-byte event logic of the JSON container splitter.
module jcs_parser
  import jcs_pkg::*;
#(
  parameter int MAX_DEPTH = 255,
  parameter int TEXT_LEN  = 65536
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         step_i,
  input  logic [7:0]   byte_i,
  input  logic         last_i,
  output logic         ev_valid_o,
  output event_kind_e  ev_kind_o,
  output logic [15:0]  ev_offset_o,
  output parser_stat_t stat_o
);

  localparam int DW = $clog2(MAX_DEPTH + 1);
  localparam int PW = $clog2(TEXT_LEN);

  char_class_t cc;
  phase_e      phase_q, phase_d;
  logic        obj_q, obj_d;
  logic [DW-1:0] depth_q, depth_d;
  logic        in_str_q, in_str_d;
  logic        after_bs_q, after_bs_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [31:0] pos_ext;

  logic        closes;
  logic        any_close;
  logic        any_open;
  logic        can_start;
  logic        av_event;
  event_kind_e av_kind;
  phase_e      av_phase;
  logic        ev_valid;
  event_kind_e ev_kind;

  jcs_classify u_classify (
    .byte_i  (byte_i),
    .class_o (cc)
  );

  assign any_open  = cc.lbrack | cc.lbrace;
  assign any_close = cc.rbrack | cc.rbrace;
  assign closes    = obj_q ? cc.rbrace : cc.rbrack;
  assign can_start = !(cc.comma | cc.colon | any_close);

  // Outcome of a byte that follows a complete value.
  always_comb begin
    av_event = 1'b0;
    av_kind  = EV_ERROR;
    av_phase = PH_AFTER_VALUE;
    if (cc.white) begin
      av_event = 1'b0;
    end else if (cc.comma) begin
      av_phase = PH_NEED_ITEM;
    end else if (closes) begin
      av_phase = PH_DRAIN;
      av_event = 1'b1;
      av_kind  = EV_CLOSED;
    end else begin
      av_event = 1'b1;
    end
  end

  // Next state and event for the current byte.
  always_comb begin
    phase_d    = phase_q;
    obj_d      = obj_q;
    depth_d    = depth_q;
    in_str_d   = in_str_q;
    after_bs_d = after_bs_q;
    pos_d      = pos_q;
    ev_valid   = 1'b0;
    ev_kind    = EV_ERROR;

    unique case (phase_q)
      PH_IDLE: begin
        if (cc.white) begin
          ev_valid = 1'b0;
        end else if (cc.lbrack) begin
          obj_d   = 1'b0;
          phase_d = PH_OPENED;
        end else if (cc.lbrace) begin
          obj_d   = 1'b1;
          phase_d = PH_OPENED;
        end else begin
          ev_valid = 1'b1;
        end
      end
      PH_OPENED, PH_NEED_ITEM: begin
        if (cc.white) begin
          ev_valid = 1'b0;
        end else if (phase_q == PH_OPENED && closes) begin
          ev_valid = 1'b1;
          ev_kind  = EV_CLOSED;
          phase_d  = PH_DRAIN;
        end else if (obj_q) begin
          ev_valid = 1'b1;
          if (cc.quote) begin
            in_str_d   = 1'b1;
            after_bs_d = 1'b0;
            phase_d    = PH_KEY;
            ev_kind    = EV_KEY;
          end
        end else begin
          ev_valid = 1'b1;
          if (can_start) begin
            depth_d    = any_open ? DW'(1) : '0;
            in_str_d   = cc.quote;
            after_bs_d = 1'b0;
            phase_d    = PH_IN_VALUE;
            ev_kind    = EV_ELEMENT;
          end
        end
      end
      PH_KEY: begin
        if (in_str_q) begin
          if (after_bs_q) begin
            after_bs_d = 1'b0;
          end else if (cc.bslash) begin
            after_bs_d = 1'b1;
          end else if (cc.quote) begin
            in_str_d = 1'b0;
          end
        end else if (cc.colon) begin
          phase_d = PH_NEED_VALUE;
        end else if (!cc.white) begin
          ev_valid = 1'b1;
        end
      end
      PH_NEED_VALUE: begin
        if (!cc.white) begin
          ev_valid = 1'b1;
          if (can_start) begin
            depth_d    = any_open ? DW'(1) : '0;
            in_str_d   = cc.quote;
            after_bs_d = 1'b0;
            phase_d    = PH_IN_VALUE;
            ev_kind    = EV_VALUE;
          end
        end
      end
      PH_IN_VALUE: begin
        if (in_str_q) begin
          if (after_bs_q) begin
            after_bs_d = 1'b0;
          end else if (cc.bslash) begin
            after_bs_d = 1'b1;
          end else if (cc.quote) begin
            in_str_d = 1'b0;
            if (depth_q == '0) begin
              phase_d = PH_AFTER_VALUE;
            end
          end
        end else if (depth_q != '0) begin
          if (cc.quote) begin
            in_str_d   = 1'b1;
            after_bs_d = 1'b0;
          end else if (any_open) begin
            if (depth_q >= DW'(MAX_DEPTH)) begin
              ev_valid = 1'b1;
            end else begin
              depth_d = depth_q + DW'(1);
            end
          end else if (any_close) begin
            depth_d = depth_q - DW'(1);
            if (depth_q == DW'(1)) begin
              phase_d = PH_AFTER_VALUE;
            end
          end
        end else if (cc.white | cc.comma | cc.colon | cc.quote | any_open | any_close) begin
          phase_d  = av_phase;
          ev_valid = av_event;
          ev_kind  = av_kind;
        end
      end
      PH_AFTER_VALUE: begin
        phase_d  = av_phase;
        ev_valid = av_event;
        ev_kind  = av_kind;
      end
      default: begin
        phase_d = phase_q;
      end
    endcase

    // An error sends the parser to drain the rest of the text.
    if (ev_valid && ev_kind == EV_ERROR) begin
      phase_d = PH_DRAIN;
    end

    // The final byte ends the text: report an error unless the parser is draining, then reset.
    if (last_i) begin
      if (phase_d != PH_DRAIN) begin
        ev_valid = 1'b1;
        ev_kind  = EV_ERROR;
      end
      phase_d    = PH_IDLE;
      obj_d      = 1'b0;
      depth_d    = '0;
      in_str_d   = 1'b0;
      after_bs_d = 1'b0;
      pos_d      = '0;
    end else if (pos_q < PW'(TEXT_LEN - 1)) begin
      pos_d = pos_q + PW'(1);
    end
  end

  // Parser state registers, updated once per processed byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      obj_q      <= 1'b0;
      depth_q    <= '0;
      in_str_q   <= 1'b0;
      after_bs_q <= 1'b0;
      pos_q      <= '0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      obj_q      <= obj_d;
      depth_q    <= depth_d;
      in_str_q   <= in_str_d;
      after_bs_q <= after_bs_d;
      pos_q      <= pos_d;
    end
  end

  assign pos_ext     = 32'(pos_q);
  assign ev_valid_o  = ev_valid;
  assign ev_kind_o   = ev_kind;
  assign ev_offset_o = pos_ext[15:0];

  // Status for checks at the top level.
  assign stat_o.idle  = (phase_q == PH_IDLE);
  assign stat_o.clean = (depth_q == '0) && !in_str_q && !after_bs_q && (pos_q == '0);

endmodule

### sv/json_container_splitter_core.sv
// A byte in the input register is parsed when the event register has room, and its event
// is loaded into the event register and presented on the master port from then on.
// Throughput: one byte per cycle while no event waits; input register and parser step as one.
// A waiting event stalls the parser; the input register then holds one byte and input stalls.
// Reset: asynchronous, active low; the parser returns to idle at offset zero, no event pending.
// After the final byte of a text the parser also returns to that idle state by itself.
module json_container_splitter_core
  import jcs_pkg::*;
#(
  parameter int MAX_DEPTH = 255,
  parameter int TEXT_LEN  = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  logic        s_axis_tlast,   // final_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] byte_offset
  output logic [2:0]  m_axis_tuser    // [2:0] event_kind
);

  logic         in_valid_q;
  logic [7:0]   in_data_q;
  logic         in_last_q;
  logic         out_valid_q;
  event_kind_e  out_kind_q;
  logic [15:0]  out_offset_q;
  logic         out_room;
  logic         advance;
  logic         ev_valid;
  event_kind_e  ev_kind;
  logic [15:0]  ev_offset;
  parser_stat_t stat;

  // The held byte is processed when the event register can take its result.
  assign out_room      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_room;
  assign s_axis_tready = !in_valid_q || advance;

  // Input register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_data_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  jcs_parser #(
    .MAX_DEPTH (MAX_DEPTH),
    .TEXT_LEN  (TEXT_LEN)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .byte_i      (in_data_q),
    .last_i      (in_last_q),
    .ev_valid_o  (ev_valid),
    .ev_kind_o   (ev_kind),
    .ev_offset_o (ev_offset),
    .stat_o      (stat)
  );

  // Event register valid: loaded by a processed byte, cleared by a transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= ev_valid;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Event register payload.
  always_ff @(posedge clk_i) begin
    if (advance && ev_valid) begin
      out_kind_q   <= ev_kind;
      out_offset_q <= ev_offset;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_offset_q;
  assign m_axis_tuser  = out_kind_q;

`ifndef ASSERT_OFF
  // The final byte of a text leaves the parser idle and cleared.
  a_idle_after_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_last_q |=> stat.idle && stat.clean)
    else $error("parser not idle after final byte");

  // A byte waiting for room is held unchanged in the input register.
  a_hold_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !out_room |=> in_valid_q && $stable(in_data_q) && $stable(in_last_q))
    else $error("input byte lost while stalled");

  // Every event from a processed byte is presented on the master port.
  a_event_shown : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && ev_valid |=> m_axis_tvalid && (m_axis_tdata == $past(ev_offset)))
    else $error("event not presented");
`endif

endmodule
